/* rtl/core/gput_pkg.sv */
// ----------------------------------------------------------------------------
// gput_pkg
// Shared types and constants for the general purpose up-counting timer.
// ----------------------------------------------------------------------------
package gput_pkg;

    localparam int DATA_W = 16;

    // Register bit positions
    localparam int CR_COUNT_EN_POS = 0;
    localparam int CR_PRELOAD_POS  = 7;
    localparam int IE_UPDATE_POS   = 0;
    localparam int SR_UPDATE_POS   = 0;
    localparam int EG_UPDATE_POS   = 0;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        REG_CTRL   = 3'd0,
        REG_IRQ_EN = 3'd1,
        REG_STATUS = 3'd2,
        REG_EGR    = 3'd3,
        REG_COUNT  = 3'd4,
        REG_PRESC  = 3'd5,
        REG_RELOAD = 3'd6
    } reg_sel_t;

    // One accepted bus item as it travels from the input register to the core
    typedef struct packed {
        logic              step;
        logic [1:0]        command;
        logic [2:0]        reg_select;
        logic [DATA_W-1:0] write_data;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              update_flag;
        logic              irq;
    } result_t;

endpackage

/* rtl/core/gput_in_if.sv */
// ----------------------------------------------------------------------------
// gput_in_if
// Request channel of the timer: command, register select and write data.
// ----------------------------------------------------------------------------
interface gput_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [2:0]  reg_select;
    logic [15:0] write_data;

    modport source (output valid, output command, output reg_select,
                    output write_data, input ready);
    modport sink   (input valid, input command, input reg_select,
                    input write_data, output ready);
endinterface

/* rtl/core/gput_out_if.sv */
// ----------------------------------------------------------------------------
// gput_out_if
// Response channel of the timer: read data, update flag and interrupt.
// ----------------------------------------------------------------------------
interface gput_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic        update_flag;
    logic        irq;

    modport source (output valid, output read_data, output update_flag,
                    output irq, input ready);
    modport sink   (input valid, input read_data, input update_flag,
                    input irq, output ready);
endinterface

/* rtl/core/gput_core.sv */
// ----------------------------------------------------------------------------
// gput_core
// Timer register file, prescaler and counter. Applies one item per step and
// presents the result for the same item combinationally.
// ----------------------------------------------------------------------------
module gput_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  gput_pkg::item_t  item,
    output gput_pkg::result_t result
);
    import gput_pkg::*;

    logic                   cen_reg, cen_next;
    logic                   arpe_reg, arpe_next;
    logic                   uie_reg, uie_next;
    logic                   uif_reg, uif_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [COUNT_WIDTH-1:0] psc_cnt_reg, psc_cnt_next;
    logic [COUNT_WIDTH-1:0] psc_wr_reg, psc_wr_next;
    logic [COUNT_WIDTH-1:0] psc_act_reg, psc_act_next;
    logic [COUNT_WIDTH-1:0] arr_wr_reg, arr_wr_next;
    logic [COUNT_WIDTH-1:0] arr_act_reg, arr_act_next;

    logic [COUNT_WIDTH-1:0] wdata;
    logic                   is_write;
    logic                   psc_wrap;
    logic                   cnt_hit;
    logic                   upd_evt;
    logic [DATA_W-1:0]      rdata;

    assign wdata    = COUNT_WIDTH'(item.write_data);
    assign is_write = item.step && (item.command == CMD_WRITE);
    assign psc_wrap = psc_cnt_reg >= psc_act_reg;
    assign cnt_hit  = cnt_reg == arr_act_reg;

    // Update event comes from a counter wrap at the reload value or a UG write.
    always_comb
    begin
        upd_evt = 1'b0;
        if (item.step && item.command == CMD_TICK && cen_reg && psc_wrap && cnt_hit)
        begin
            upd_evt = 1'b1;
        end
        if (is_write && item.reg_select == REG_EGR && item.write_data[EG_UPDATE_POS])
        begin
            upd_evt = 1'b1;
        end
    end

    always_comb
    begin
        cen_next     = cen_reg;
        arpe_next    = arpe_reg;
        uie_next     = uie_reg;
        uif_next     = uif_reg;
        cnt_next     = cnt_reg;
        psc_cnt_next = psc_cnt_reg;
        psc_wr_next  = psc_wr_reg;
        psc_act_next = psc_act_reg;
        arr_wr_next  = arr_wr_reg;
        arr_act_next = arr_act_reg;

        if (item.step && item.command == CMD_TICK && cen_reg)
        begin
            if (psc_wrap)
            begin
                psc_cnt_next = '0;
                cnt_next     = cnt_reg + COUNT_WIDTH'(1);
            end
            else
            begin
                psc_cnt_next = psc_cnt_reg + COUNT_WIDTH'(1);
            end
        end

        if (is_write)
        begin
            unique case (item.reg_select)
                REG_CTRL:
                begin
                    cen_next  = item.write_data[CR_COUNT_EN_POS];
                    arpe_next = item.write_data[CR_PRELOAD_POS];
                end
                REG_IRQ_EN: uie_next = item.write_data[IE_UPDATE_POS];
                REG_STATUS:
                begin
                    if (!item.write_data[SR_UPDATE_POS])
                    begin
                        uif_next = 1'b0;
                    end
                end
                REG_COUNT:  cnt_next = wdata;
                REG_PRESC:  psc_wr_next = wdata;
                REG_RELOAD:
                begin
                    arr_wr_next = wdata;
                    if (!arpe_reg)
                    begin
                        arr_act_next = wdata;
                    end
                end
                default: ;
            endcase
        end

        if (upd_evt)
        begin
            cnt_next     = '0;
            psc_cnt_next = '0;
            psc_act_next = psc_wr_reg;
            arr_act_next = arr_wr_reg;
            uif_next     = 1'b1;
        end
    end

    always_comb
    begin
        case (item.reg_select)
            REG_CTRL:
            begin
                rdata                  = '0;
                rdata[CR_COUNT_EN_POS] = cen_reg;
                rdata[CR_PRELOAD_POS]  = arpe_reg;
            end
            REG_IRQ_EN: rdata = DATA_W'(uie_reg);
            REG_STATUS: rdata = DATA_W'(uif_reg);
            REG_COUNT:  rdata = DATA_W'(cnt_reg);
            REG_PRESC:  rdata = DATA_W'(psc_wr_reg);
            REG_RELOAD: rdata = DATA_W'(arr_wr_reg);
            default:    rdata = '0;
        endcase
    end

    assign result.read_data   = (item.command == CMD_READ) ? rdata : '0;
    assign result.update_flag = uif_next;
    assign result.irq         = uif_next && uie_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cen_reg     <= 1'b0;
            arpe_reg    <= 1'b0;
            uie_reg     <= 1'b0;
            uif_reg     <= 1'b0;
            cnt_reg     <= '0;
            psc_cnt_reg <= '0;
            psc_wr_reg  <= '0;
            psc_act_reg <= '0;
            arr_wr_reg  <= '1;
            arr_act_reg <= '1;
        end
        else if (item.step)
        begin
            cen_reg     <= cen_next;
            arpe_reg    <= arpe_next;
            uie_reg     <= uie_next;
            uif_reg     <= uif_next;
            cnt_reg     <= cnt_next;
            psc_cnt_reg <= psc_cnt_next;
            psc_wr_reg  <= psc_wr_next;
            psc_act_reg <= psc_act_next;
            arr_wr_reg  <= arr_wr_next;
            arr_act_reg <= arr_act_next;
        end
    end

endmodule

/* rtl/core/general_purpose_up_timer_top.sv */
// ----------------------------------------------------------------------------
// general_purpose_up_timer_top
// Up-counting timer with prescaler, auto-reload and update interrupt.
//
//   Port   Direction  Carries
//   req    sink       command, reg_select, write_data
//   rsp    source     read_data, update_flag, irq
//
// An item is taken into the input register, applied to the timer state as it
// leaves the input register, and its result is held in the output register;
// one item per cycle is sustained while rsp is not stalled. The single update
// per item (prescaler compare and counter increment) sets the cycle time.
// Reset clears the other timer registers; reload values reset to all ones.
// While rsp is stalled both registers fill and req.ready drops.
// ----------------------------------------------------------------------------
module general_purpose_up_timer_top #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    gput_in_if.sink   req,
    gput_out_if.source rsp
);
    import gput_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    logic    in_xfer;
    logic    advance;
    item_t   core_item;
    result_t core_res;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign in_xfer   = req.valid && req.ready;

    assign in_valid_next  = in_xfer || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !rsp.ready);

    always_comb
    begin
        core_item      = in_item_reg;
        core_item.step = advance;
    end

    gput_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (core_item),
        .result(core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_item_reg.step       <= 1'b1;
            in_item_reg.command    <= req.command;
            in_item_reg.reg_select <= req.reg_select;
            in_item_reg.write_data <= req.write_data;
        end
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_data   = out_res_reg.read_data;
    assign rsp.update_flag = out_res_reg.update_flag;
    assign rsp.irq         = out_res_reg.irq;

endmodule

/* rtl/core/gput_checker.sv */
// ----------------------------------------------------------------------------
// gput_checker
// Port-level checks on the timer's request and response transfers.
// ----------------------------------------------------------------------------
module gput_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [15:0] rsp_read_data,
    input logic        rsp_update_flag,
    input logic        rsp_irq
);
    logic [1:0] inflight_reg, inflight_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = req_valid && req_ready;
    assign out_xfer = rsp_valid && rsp_ready;
    assign inflight_next = inflight_reg + {1'b0, in_xfer} - {1'b0, out_xfer};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 2'd0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // The interrupt is never raised without the flag behind it.
    a_irq_needs_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (!rsp_irq || rsp_update_flag))
        else $error("irq set while update flag is clear");

    // At most two items sit between the request and response sides.
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg != 2'd3 && (!rsp_valid || inflight_reg != 2'd0))
        else $error("response without request or too many items in flight");

    // The request side only stalls when the response side is back-pressured.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (rsp_valid && !rsp_ready))
        else $error("request stalled while response side is free");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_read_data)
            && $stable(rsp_update_flag) && $stable(rsp_irq)))
        else $error("stalled response changed");

endmodule

bind general_purpose_up_timer_top gput_checker u_gput_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_read_data  (rsp.read_data),
    .rsp_update_flag(rsp.update_flag),
    .rsp_irq        (rsp.irq)
);
